### rtl/bfi_pkg.sv
// Package for the Bloom filter insert block: types and constants.
package bfi_pkg;

  localparam int unsigned HashW      = 16;
  localparam int unsigned NumHash    = 4;
  localparam int unsigned WordAddrW  = 14;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned WordW      = 64;
  localparam int unsigned BitSelW    = 6;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned InDataW    = 80;
  localparam int unsigned OutDataW   = 64;

  localparam logic [ProdW-1:0] GoldenMult  = 32'h9E37_79B9;
  localparam logic [CfgW-1:0]  MinIdxBits  = 5'd16;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StRmwRd,
    StRmwWr,
    StRd,
    StRHold
  } state_e;

endpackage

### rtl/bloom_filter_insert.sv
// Top level of the Bloom filter insert block: sequencer, multiplier and word store.
//
// Input stream (s_axis): tuser selects insert or read; tdata carries four 16-bit
// hash words and a store word address. An insert runs each hash word through
// one shared 16x32 multiplier, masks the product to the configured filter size
// and sets that bit with a read-modify-write on the single-ported word memory.
// An insert runs one multiply state, then a read and a write state per hash word,
// and returns nothing; s_axis_tready is low meanwhile.
// A read runs states StRd and StRHold: the addressed word goes through the
// memory's read register into the output register and then appears on m_axis.
// If the output register still holds an untaken word, the read waits
// for m_axis_tready before finishing; inserts proceed regardless.
// Reset clears all 2^(MAX_INDEX_BITS-6) store words (16384 at the default),
// one word written per cycle, before s_axis_tready first rises.
// The size register (cfg_wdata_i) is written whenever cfg_we_i is high and
// does not clear the store.
module bloom_filter_insert #(
  parameter int unsigned MAX_INDEX_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfi_pkg::CfgW-1:0]      cfg_wdata_i,   // index_bits
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // hash_w0 [15:0], hash_w1 [31:16], hash_w2 [47:32], hash_w3 [63:48],
  // word_addr [77:64], zero [79:78]
  input  logic [bfi_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bfi_pkg::OutDataW-1:0]  m_axis_tdata   // read_word
);

  localparam int unsigned AddrW = MAX_INDEX_BITS - bfi_pkg::BitSelW;
  localparam int unsigned Depth = 2 ** AddrW;
  localparam int unsigned IdxW  = MAX_INDEX_BITS;
  localparam int unsigned EffW  = bfi_pkg::BitSelW;
  localparam logic [EffW-1:0] MaxBits = EffW'(MAX_INDEX_BITS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam int unsigned HashAllW = bfi_pkg::HashW * bfi_pkg::NumHash;

  bfi_pkg::state_e state_q, state_d;

  logic [bfi_pkg::CfgW-1:0]     cfg_q;
  logic [AddrW-1:0]             clr_q;
  logic [1:0]                   step_q;
  logic [HashAllW-1:0]          hash_q;
  logic [AddrW-1:0]             raddr_q;
  logic [IdxW-1:0]              idx_q;
  logic [AddrW-1:0]             waddr_q;
  logic [bfi_pkg::BitSelW-1:0]  wbit_q;
  logic [bfi_pkg::WordW-1:0]    rdata_q;
  logic                         m_valid_q;
  logic [bfi_pkg::WordW-1:0]    m_data_q;

  logic [bfi_pkg::WordW-1:0]    filter_mem [Depth];

  logic                         in_xfer;
  logic                         out_load;
  logic [EffW-1:0]              eff_bits;
  logic [IdxW-1:0]              idx_mask;
  logic [1:0]                   seed_sel;
  logic [bfi_pkg::HashW-1:0]    seed;
  logic [bfi_pkg::ProdW-1:0]    prod;
  logic [IdxW-1:0]              idx_new;

  logic                         mem_en;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_addr;
  logic [bfi_pkg::WordW-1:0]    mem_wdata;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == bfi_pkg::StRHold) && (!m_valid_q || m_axis_tready);

  // Effective size: clamp register to [16, MAX_INDEX_BITS]
  always_comb begin
    if (cfg_q < bfi_pkg::MinIdxBits) begin
      eff_bits = EffW'(bfi_pkg::MinIdxBits);
    end else if (EffW'(cfg_q) > MaxBits) begin
      eff_bits = MaxBits;
    end else begin
      eff_bits = EffW'(cfg_q);
    end
  end

  always_comb begin
    for (int i = 0; i < IdxW; i++) begin
      idx_mask[i] = (EffW'(i) < eff_bits);
    end
  end

  // Shared multiplier
  assign seed_sel = (state_q == bfi_pkg::StMul) ? step_q : step_q + 2'd1;
  assign seed     = hash_q[seed_sel*bfi_pkg::HashW +: bfi_pkg::HashW];
  assign prod     = bfi_pkg::ProdW'({16'd0, seed}) * bfi_pkg::GoldenMult;
  assign idx_new  = prod[IdxW-1:0] & idx_mask;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfi_pkg::StClear: begin
        if (clr_q == LastAddr) state_d = bfi_pkg::StIdle;
      end
      bfi_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = (s_axis_tuser == bfi_pkg::OpRead) ? bfi_pkg::StRd : bfi_pkg::StMul;
        end
      end
      bfi_pkg::StMul:   state_d = bfi_pkg::StRmwRd;
      bfi_pkg::StRmwRd: state_d = bfi_pkg::StRmwWr;
      bfi_pkg::StRmwWr: begin
        state_d = (step_q == 2'd3) ? bfi_pkg::StIdle : bfi_pkg::StRmwRd;
      end
      bfi_pkg::StRd:    state_d = bfi_pkg::StRHold;
      bfi_pkg::StRHold: begin
        if (out_load) state_d = bfi_pkg::StIdle;
      end
      default:          state_d = bfi_pkg::StIdle;
    endcase
  end

  // Outputs and memory control
  always_comb begin
    s_axis_tready = 1'b0;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = raddr_q;
    mem_wdata     = '0;
    unique case (state_q)
      bfi_pkg::StClear: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      bfi_pkg::StIdle: begin
        s_axis_tready = 1'b1;
      end
      bfi_pkg::StRmwRd: begin
        mem_en   = 1'b1;
        mem_addr = idx_q[IdxW-1:bfi_pkg::BitSelW];
      end
      bfi_pkg::StRmwWr: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = waddr_q;
        mem_wdata = rdata_q | (bfi_pkg::WordW'(1) << wbit_q);
      end
      bfi_pkg::StRd: begin
        mem_en   = 1'b1;
        mem_addr = raddr_q;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bfi_pkg::StClear;
      cfg_q     <= bfi_pkg::MinIdxBits;
      clr_q     <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (state_q == bfi_pkg::StClear) clr_q <= clr_q + AddrW'(1);
      if (in_xfer) begin
        step_q <= '0;
      end else if (state_q == bfi_pkg::StRmwWr) begin
        step_q <= step_q + 2'd1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hash_q  <= s_axis_tdata[HashAllW-1:0];
      raddr_q <= AddrW'(s_axis_tdata[HashAllW +: bfi_pkg::WordAddrW]);
    end
    if (state_q == bfi_pkg::StMul || state_q == bfi_pkg::StRmwRd) begin
      idx_q <= idx_new;
    end
    if (state_q == bfi_pkg::StRmwRd) begin
      waddr_q <= idx_q[IdxW-1:bfi_pkg::BitSelW];
      wbit_q  <= idx_q[bfi_pkg::BitSelW-1:0];
    end
    if (out_load) m_data_q <= rdata_q;
  end

  // Single-ported word store
  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_we) begin
        filter_mem[mem_addr] <= mem_wdata;
      end else begin
        rdata_q <= filter_mem[mem_addr];
      end
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for bloom_filter_insert: random and directed inserts/reads vs a word-store model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxIdxBits   = 20;
  localparam int unsigned StoreDepth   = 1 << (MaxIdxBits - 6);
  localparam logic [31:0] HashMult     = 32'h9E37_79B9;
  localparam int          HoldCycles   = 400;
  localparam int          SettleCycles = 16;
  localparam int          PhaseItems   = 190;
  localparam int          NumPhases    = 9;

  typedef struct packed {
    logic                             op;
    logic [bfi_pkg::WordAddrW-1:0]    word_addr;
    logic [3:0][bfi_pkg::HashW-1:0]   hash;
  } filter_item_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [bfi_pkg::CfgW-1:0]      cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bfi_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic                          s_axis_tuser  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bfi_pkg::OutDataW-1:0]  m_axis_tdata;

  logic [63:0]              filter_words [StoreDepth];
  logic [bfi_pkg::CfgW-1:0] size_reg = 5'd16;
  logic [63:0]              expected_words [$];
  filter_item_t             pend_q [$];
  logic [13:0]              touched_words [$];
  filter_item_t             cur_item;
  logic [63:0]              exp_word;
  bit                       in_taken  = 1'b0;
  bit                       hold_req  = 1'b0;
  int                       hold_left = 0;
  int                       in_flight = 0;
  int                       errors    = 0;
  int                       idle_pct  = 0;
  int                       stall_pct = 0;

  always #4 clk_i = ~clk_i;

  bloom_filter_insert #(
    .MAX_INDEX_BITS(MaxIdxBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic logic [31:0] bit_index(logic [15:0] seed, logic [4:0] bits);
    int unsigned eff;
    logic [31:0] mask;
    eff  = (bits < 16) ? 16 : ((bits > MaxIdxBits) ? MaxIdxBits : bits);
    mask = 32'((64'd1 << eff) - 64'd1);
    return ({16'd0, seed} * HashMult) & mask;
  endfunction

  function automatic logic [13:0] word_of(logic [15:0] seed, logic [4:0] bits);
    logic [31:0] idx;
    idx = bit_index(seed, bits);
    return idx[MaxIdxBits-1:6];
  endfunction

  // Advance the filter model by one accepted transfer.
  task automatic set_or_fetch(filter_item_t it);
    logic [31:0] idx;
    int k;
    if (it.op == bfi_pkg::OpInsert) begin
      for (k = 0; k < 4; k++) begin
        idx = bit_index(it.hash[k], size_reg);
        filter_words[idx[MaxIdxBits-1:6]][idx[5:0]] = 1'b1;
      end
    end else begin
      expected_words.push_back(filter_words[it.word_addr]);
    end
  endtask

  function automatic filter_item_t mk_item(logic op, logic [15:0] h0, logic [15:0] h1,
                                           logic [15:0] h2, logic [15:0] h3,
                                           logic [13:0] addr);
    filter_item_t it;
    it.op        = op;
    it.hash      = {h3, h2, h1, h0};
    it.word_addr = addr;
    return it;
  endfunction

  function automatic filter_item_t rand_item();
    filter_item_t it;
    int k;
    int r;
    it.op        = ($urandom_range(99) < 55) ? bfi_pkg::OpInsert : bfi_pkg::OpRead;
    it.word_addr = 14'($urandom_range(StoreDepth - 1));
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(9) == 0) it.hash[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else it.hash[k] = 16'($urandom);
    end
    if (it.op == bfi_pkg::OpInsert) begin
      for (k = 0; k < 4; k++) touched_words.push_back(word_of(it.hash[k], size_reg));
    end else begin
      r = $urandom_range(99);
      if (r < 50 && touched_words.size() != 0) begin
        it.word_addr = touched_words[$urandom_range(touched_words.size() - 1)];
      end else if (r < 80) begin
        it.word_addr = word_of(16'($urandom), size_reg);
      end
    end
    return it;
  endfunction

  task automatic queue_item(filter_item_t it);
    pend_q.push_back(it);
    in_flight++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (in_flight != 0 || expected_words.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_size(logic [4:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    size_reg     = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Sender
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_item = pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cur_item.word_addr, cur_item.hash};
        s_axis_tuser  <= cur_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: output transfers are checked before the input transfer is applied
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 100)
            $display("%0t: read_word expected none, got %h", $time, m_axis_tdata);
        end else begin
          exp_word = expected_words.pop_front();
          if (m_axis_tdata !== exp_word) begin
            errors++;
            if (errors <= 100)
              $display("%0t: read_word expected %h, got %h", $time, exp_word, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        in_flight--;
        set_or_fetch(cur_item);
      end
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [4:0] size_plan [NumPhases];
    int idle_tab [4];
    int stall_tab [4];
    int p;
    int n;
    size_plan = '{5'd20, 5'd0, 5'd31, 5'd17, 5'd21, 5'd18, 5'd15, 5'd19, 5'd16};
    idle_tab  = '{0, 45, 0, 33};
    stall_tab = '{0, 0, 45, 33};
    foreach (filter_words[i]) filter_words[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset size
    queue_item(mk_item(bfi_pkg::OpInsert, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'h3FFF));
    queue_item(mk_item(bfi_pkg::OpInsert, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h0000));
    queue_item(mk_item(bfi_pkg::OpInsert, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 14'h2AAA));
    queue_item(mk_item(bfi_pkg::OpInsert, 16'h00FF, 16'hFF00, 16'h1234, 16'hFEDC, 14'h1555));
    queue_item(mk_item(bfi_pkg::OpRead, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h0000));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                       word_of(16'hFFFF, size_reg)));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF,
                       word_of(16'h0001, size_reg)));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                       word_of(16'h8000, size_reg)));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                       word_of(16'h5555, size_reg)));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                       word_of(16'hAAAA, size_reg)));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                       word_of(16'h1234, size_reg)));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'd1023));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'd1024));
    queue_item(mk_item(bfi_pkg::OpRead, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'h3FFF));
    wait_idle();

    for (p = 0; p < NumPhases; p++) begin
      write_size(size_plan[p]);
      @(posedge clk_i);
      idle_pct  = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      if (p == 2) hold_req = 1'b1;
      for (n = 0; n < PhaseItems; n++) queue_item(rand_item());
      wait_idle();
    end

    if (errors == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
